// ===== design/hec_pkg.sv =====
// ---------------------------------------------------------------------------
// hec_pkg: shared types, constants and functions
// Widths, register map, function codes and the constant helpers that lay out
// data bits and parity groups of the variable-size Hamming code.
// ---------------------------------------------------------------------------
package hec_pkg;

    localparam int MAX_DATA = 57;
    localparam int DATA_W   = 57;
    localparam int WORD_W   = 63;
    localparam int POS_W    = 6;
    localparam int CHK_W    = 3;

    localparam logic [POS_W-1:0] DATA_LEN_RESET = 6'd4;

    // APB register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // stream payload widths
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_FIELD_W = 76;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [0:0] {
        REG_DATA_LEN = 1'b0
    } reg_idx_t;

    typedef enum logic [0:0] {
        FUNC_ENCODE = 1'b0,
        FUNC_CHECK  = 1'b1
    } func_t;

    typedef struct packed {
        logic [POS_W-1:0] eff_len;
        logic [POS_W-1:0] code_len;
    } cfg_t;

    // least m with 2^m >= n + m + 1, for n in 1..57
    function automatic logic [CHK_W-1:0] check_bits(input logic [POS_W-1:0] n);
        logic [CHK_W-1:0] m;
        if (n <= 6'd1)
        begin
            m = 3'd2;
        end
        else if (n <= 6'd4)
        begin
            m = 3'd3;
        end
        else if (n <= 6'd11)
        begin
            m = 3'd4;
        end
        else if (n <= 6'd26)
        begin
            m = 3'd5;
        end
        else
        begin
            m = 3'd6;
        end
        return m;
    endfunction

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // data bit index held at a non-power-of-two position p
    function automatic int data_index(input int p);
        int n_pow;
        n_pow = 0;
        for (int q = 1; q <= p; q = q * 2)
        begin
            n_pow = n_pow + 1;
        end
        return p - n_pow - 1;
    endfunction

    // positions that take part in syndrome bit b
    function automatic logic [WORD_W-1:0] syn_mask(input int b);
        logic [WORD_W-1:0] mask;
        mask = '0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            mask[p-1] = ((p >> b) & 1) != 0;
        end
        return mask;
    endfunction

endpackage

// ===== design/hec_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// hec_cfg_regs: APB configuration register
// Holds the data length register and derives the clamped data length and the
// codeword length from it.
// ---------------------------------------------------------------------------
module hec_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hec_pkg::PADDR_W-1:0] paddr,
    input  logic [hec_pkg::PDATA_W-1:0] pwdata,
    output logic [hec_pkg::PDATA_W-1:0] prdata,
    output hec_pkg::cfg_t               cfg
);

    logic [hec_pkg::POS_W-1:0] data_len_reg;
    logic [hec_pkg::POS_W-1:0] data_len_next;
    logic [hec_pkg::POS_W-1:0] eff_len;
    logic                      wr_en;
    logic                      sel_data_len;

    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[hec_pkg::PADDR_W-1])
            hec_pkg::REG_DATA_LEN: sel_data_len = 1'b1;
            default:               sel_data_len = 1'b0;
        endcase
    end

    always_comb
    begin
        data_len_next = data_len_reg;
        if (wr_en && sel_data_len)
        begin
            data_len_next = pwdata[hec_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_len_reg <= hec_pkg::DATA_LEN_RESET;
        end
        else
        begin
            data_len_reg <= data_len_next;
        end
    end

    assign prdata = sel_data_len
                  ? {{(hec_pkg::PDATA_W - hec_pkg::POS_W){1'b0}}, data_len_reg}
                  : '0;

    // clamp zero up to one and saturate above the largest data length
    always_comb
    begin
        if (data_len_reg == '0)
        begin
            eff_len = hec_pkg::POS_W'(1);
        end
        else if (data_len_reg > hec_pkg::POS_W'(hec_pkg::MAX_DATA))
        begin
            eff_len = hec_pkg::POS_W'(hec_pkg::MAX_DATA);
        end
        else
        begin
            eff_len = data_len_reg;
        end
    end

    assign cfg.eff_len  = eff_len;
    assign cfg.code_len = eff_len
                        + {{(hec_pkg::POS_W - hec_pkg::CHK_W){1'b0}},
                           hec_pkg::check_bits(eff_len)};

endmodule

// ===== design/hec_syndrome.sv =====
// ---------------------------------------------------------------------------
// hec_syndrome: syndrome XOR network
// XORs the positions of all set bits of a 63-bit word.
// ---------------------------------------------------------------------------
module hec_syndrome (
    input  logic [hec_pkg::WORD_W-1:0] word,
    output logic [hec_pkg::POS_W-1:0]  syn
);

    for (genvar b = 0; b < hec_pkg::POS_W; b++)
    begin : g_syn
        assign syn[b] = ^(word & hec_pkg::syn_mask(b));
    end

endmodule

// ===== design/hec_codec.sv =====
// ---------------------------------------------------------------------------
// hec_codec: encode and check datapath
// Scatters data bits over the non-power-of-two positions, or masks a received
// word to the codeword length, and runs both through one syndrome network.
// ---------------------------------------------------------------------------
module hec_codec (
    input  logic                        func,
    input  logic [hec_pkg::DATA_W-1:0]  data_bits,
    input  logic [hec_pkg::WORD_W-1:0]  received_word,
    input  hec_pkg::cfg_t               cfg,
    output logic [hec_pkg::WORD_W-1:0]  code_word,
    output logic                        error_found,
    output logic [hec_pkg::POS_W-1:0]   error_position
);

    logic [hec_pkg::DATA_W-1:0] data_mask;
    logic [hec_pkg::DATA_W-1:0] data_used;
    logic [hec_pkg::WORD_W-1:0] len_mask;
    logic [hec_pkg::WORD_W-1:0] scat;
    logic [hec_pkg::WORD_W-1:0] parity_bits;
    logic [hec_pkg::WORD_W-1:0] syn_in;
    logic [hec_pkg::POS_W-1:0]  syn;
    logic                       is_check;

    assign is_check = (func == hec_pkg::FUNC_CHECK);

    always_comb
    begin
        for (int k = 0; k < hec_pkg::DATA_W; k++)
        begin
            data_mask[k] = hec_pkg::POS_W'(k) < cfg.eff_len;
        end
        for (int p = 0; p < hec_pkg::WORD_W; p++)
        begin
            len_mask[p] = hec_pkg::POS_W'(p) < cfg.code_len;
        end
    end

    assign data_used = data_bits & data_mask;

    // data bit k lands at the k-th position that is not a power of two
    for (genvar p = 1; p <= hec_pkg::WORD_W; p++)
    begin : g_scat
        if (hec_pkg::is_pow2(p))
        begin : g_chk
            assign scat[p-1] = 1'b0;
        end
        else
        begin : g_dat
            assign scat[p-1] = data_used[hec_pkg::data_index(p)];
        end
    end

    assign syn_in = is_check ? (received_word & len_mask) : scat;

    hec_syndrome u_syndrome (
        .word (syn_in),
        .syn  (syn)
    );

    always_comb
    begin
        parity_bits = '0;
        for (int i = 0; i < hec_pkg::POS_W; i++)
        begin
            parity_bits[(1 << i) - 1] = syn[i];
        end
    end

    always_comb
    begin
        if (is_check)
        begin
            code_word      = '0;
            error_found    = |syn;
            error_position = syn;
        end
        else
        begin
            code_word      = scat | parity_bits;
            error_found    = 1'b0;
            error_position = '0;
        end
    end

endmodule

// ===== design/hamming_encode_and_check_core.sv =====
// ---------------------------------------------------------------------------
// hamming_encode_and_check_core: variable-size Hamming encoder and checker
// Encodes data words into even-parity Hamming codewords or computes the
// syndrome of received words, with the data length set over APB.
// ---------------------------------------------------------------------------
// The core takes one transaction per clock cycle while the output side is
// not stalled and returns exactly one result transaction for each: an input
// register captures the transaction, one XOR network of at most 63 inputs per
// syndrome bit (shared by encode and check) evaluates it, and an output
// register holds the result. The data length register (address 0, reset 4)
// is clamped to 1..57; the codeword length is n plus the least m with
// 2^m >= n + m + 1. Write the register only while no transaction is in
// flight. In encode mode (tuser = 0) the result carries the codeword with
// data bit 0 at position 3 and bit p-1 holding position p;
// in check mode (tuser = 1) it carries the syndrome, which is the position of
// a single flipped bit, and a flag that is set when the syndrome is nonzero.
// ---------------------------------------------------------------------------
module hamming_encode_and_check_core (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hec_pkg::PADDR_W-1:0]     paddr,
    input  logic [hec_pkg::PDATA_W-1:0]     pwdata,
    output logic [hec_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [56:0] data_bits, [119:57] received_word
    input  logic [hec_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [0] func
    input  logic [0:0]                      s_tuser,

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [62:0] code_word, [68:63] code_len, [69] error_found,
    // [75:70] error_position, [79:76] zero
    output logic [hec_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int RX_LSB = hec_pkg::DATA_W;
    localparam int RX_MSB = hec_pkg::DATA_W + hec_pkg::WORD_W - 1;

    hec_pkg::cfg_t cfg;

    // input register stage
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic                             func_reg;
    logic [hec_pkg::DATA_W-1:0]       data_reg;
    logic [hec_pkg::WORD_W-1:0]       rx_reg;

    // result register stage
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [hec_pkg::WORD_W-1:0]       code_word_reg;
    logic [hec_pkg::POS_W-1:0]        code_len_reg;
    logic                             error_found_reg;
    logic [hec_pkg::POS_W-1:0]        error_position_reg;

    // datapath results
    logic [hec_pkg::WORD_W-1:0]       code_word;
    logic                             error_found;
    logic [hec_pkg::POS_W-1:0]        error_position;

    logic                             in_take;
    logic                             out_load;

    assign pready = 1'b1;

    hec_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Advance the held transaction into the result register whenever that
    // register is empty or its content is taken in the same cycle; accept a
    // new transaction whenever the input register is empty or advancing.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the payload on acceptance; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= s_tuser[0];
            data_reg <= s_tdata[hec_pkg::DATA_W-1:0];
            rx_reg   <= s_tdata[RX_MSB:RX_LSB];
        end
    end

    hec_codec u_codec (
        .func           (func_reg),
        .data_bits      (data_reg),
        .received_word  (rx_reg),
        .cfg            (cfg),
        .code_word      (code_word),
        .error_found    (error_found),
        .error_position (error_position)
    );

    // Load the result register; hold it until the transaction is taken.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            code_word_reg      <= code_word;
            code_len_reg       <= cfg.code_len;
            error_found_reg    <= error_found;
            error_position_reg <= error_position;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{hec_pkg::OUT_PAD_W{1'b0}}, error_position_reg, error_found_reg,
                       code_len_reg, code_word_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // a nonzero codeword only comes from encoding, which reports no error
    a_encode_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && code_word_reg != '0) |->
            (!error_found_reg && error_position_reg == '0))
        else $error("encode result carries error fields");

    a_flag_matches_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (error_found_reg == (error_position_reg != '0)))
        else $error("error flag disagrees with syndrome");

    a_code_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (code_len_reg >= hec_pkg::POS_W'(3)))
        else $error("codeword length below minimum");

    a_advance_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held transaction did not advance into free result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while pipeline can move");

endmodule
